// File: design/mspid_pkg.sv
// Shared types and constants for the motor speed PID with reversal guard.
`default_nettype none

package mspid_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // A request above this limit against the current direction brakes.
  localparam logic [7:0] ReversalLimit = 8'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 3'd0,
    CfgIntegGain = 3'd1,
    CfgDerivGain = 3'd2,
    CfgIntegUp   = 3'd3,
    CfgIntegLow  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] speed_fwd_req;
    logic [7:0] speed_back_req;
    logic       brake_req;
    logic [7:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_value;
    logic               drive_dir;
    logic               braked;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic signed [15:0] integ_upper;
    logic signed [15:0] integ_lower;
  } cfg_t;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    logic              braked;
    logic              dir;
    logic signed [8:0] err;
    logic signed [8:0] dmeas;
  } tick_t;

endpackage

`default_nettype wire

// File: design/mspid_front.sv
// Front: brake and reversal classification, direction and last-speed state.
`default_nettype none

module mspid_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  mspid_pkg::in_item_t in_data_i,
  input  wire                 q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output mspid_pkg::tick_t    tick_o
);
  import mspid_pkg::*;

  logic       dir_q, dir_d;
  logic [7:0] last_q, last_d;
  logic       brake;
  logic       new_dir;
  logic [7:0] req;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    brake = in_data_i.brake_req
         || (in_data_i.speed_fwd_req > ReversalLimit && !dir_q)
         || (in_data_i.speed_back_req > ReversalLimit && dir_q);
    new_dir = (in_data_i.speed_fwd_req != 8'd0);
    req     = new_dir ? in_data_i.speed_fwd_req : in_data_i.speed_back_req;

    tick_o.braked = brake;
    tick_o.dir    = brake ? dir_q : new_dir;
    tick_o.err    = $signed({1'b0, req}) - $signed({1'b0, in_data_i.measured_speed});
    tick_o.dmeas  = $signed({1'b0, last_q}) - $signed({1'b0, in_data_i.measured_speed});

    dir_d  = dir_q;
    last_d = last_q;
    if (push_o && !brake) begin
      dir_d  = new_dir;
      last_d = in_data_i.measured_speed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b1;
      last_q <= 8'd0;
    end else begin
      dir_q  <= dir_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

// File: design/mspid_queue.sv
// Short queue of classified ticks between the front and the back.
`default_nettype none

module mspid_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  mspid_pkg::tick_t push_data_i,
  input  wire              pop_i,
  output logic             full_o,
  output logic             valid_o,
  output mspid_pkg::tick_t pop_data_o
);
  import mspid_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tick_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// File: design/mspid_back.sv
// Back: integral update, gain multiplies, sum, scaling and output register.
`default_nettype none

module mspid_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mspid_pkg::cfg_t      cfg_i,
  input  wire                  q_valid_i,
  input  mspid_pkg::tick_t     q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output mspid_pkg::out_item_t out_data_o
);
  import mspid_pkg::*;

  // Stage 1: clamped integral
  logic               v1_q;
  logic               brk1_q, dir1_q;
  logic signed [8:0]  err1_q, dmeas1_q;
  logic signed [15:0] acc1_q;
  logic signed [15:0] integ_q, integ_d;
  logic signed [16:0] acc_sum;
  // Stage 2: products
  logic               v2_q;
  logic               brk2_q, dir2_q;
  logic signed [24:0] pp_q, pd_q;
  logic signed [31:0] pi_q;
  // Stage 3: output register
  logic               out_valid_q;
  out_item_t          out_q;

  logic               en1, en2, en3;
  logic signed [33:0] sum;
  logic signed [25:0] scaled;
  logic signed [15:0] drive;

  assign en3   = !out_valid_q || !out_stall_i;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = q_valid_i && en1;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    acc_sum = {integ_q[15], integ_q} + {{8{q_data_i.err[8]}}, q_data_i.err};
    integ_d = integ_q;
    if (acc_sum > $signed({cfg_i.integ_upper[15], cfg_i.integ_upper})) begin
      integ_d = cfg_i.integ_upper;
    end else if (acc_sum < $signed({cfg_i.integ_lower[15], cfg_i.integ_lower})) begin
      integ_d = cfg_i.integ_lower;
    end else begin
      integ_d = acc_sum[15:0];
    end
  end

  always_comb begin
    sum = {{9{pp_q[24]}}, pp_q} + {{2{pi_q[31]}}, pi_q} + {{9{pd_q[24]}}, pd_q};
    // Arithmetic shift gives the floor of sum / 256.
    scaled = sum[33:8];
    if (scaled[25:15] == {11{scaled[15]}}) drive = scaled[15:0];
    else if (scaled[25])                   drive = 16'sh8000;
    else                                   drive = 16'sh7fff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
    end else begin
      if (en1) v1_q <= pop_o;
      if (en2) v2_q <= v1_q;
      if (en3) out_valid_q <= v2_q;
      if (pop_o && !q_data_i.braked) integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      brk1_q   <= q_data_i.braked;
      dir1_q   <= q_data_i.dir;
      err1_q   <= q_data_i.err;
      dmeas1_q <= q_data_i.dmeas;
      acc1_q   <= integ_d;
    end
    if (en2 && v1_q) begin
      brk2_q <= brk1_q;
      dir2_q <= dir1_q;
      pp_q   <= 25'(cfg_i.prop_gain) * 25'(err1_q);
      pi_q   <= 32'(cfg_i.integ_gain) * 32'(acc1_q);
      pd_q   <= 25'(cfg_i.deriv_gain) * 25'(dmeas1_q);
    end
    if (en3 && v2_q) begin
      out_q.drive_value <= brk2_q ? 16'sd0 : drive;
      out_q.drive_dir   <= dir2_q;
      out_q.braked      <= brk2_q;
    end
  end

  // A braked tick leaves the integral untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_data_i.braked |=> $stable(integ_q))
    else $error("integral changed on braked tick");

  // A stalled result holds and the stage behind it keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && v2_q |=> out_valid_q && v2_q)
    else $error("pipeline lost an item under stall");

  // A braked result never carries drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.braked |-> out_q.drive_value == 16'sd0)
    else $error("braked result with nonzero drive");

  // Nothing is popped into stage 1 while it is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en2 |-> !pop_o)
    else $error("pop into held stage");

endmodule

`default_nettype wire

// File: design/motor_speed_pid_with_reversal_guard.sv
// Top level: configuration registers, front, tick queue and back.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one control tick
//   per transaction: forward and backward requests, brake flag, measured speed.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   transaction per tick: drive value, direction and braked flag, in order.
//   From input acceptance to output valid a tick passes the queue write, the
//   integral stage, multiply stage and sum/saturate into the output register.
//   Throughput: one tick per cycle while out_stall_i is low; the integral add
//   and clamp is the only loop in the back, the three gain multiplies sit in
//   their own stage.
//   Receiver stall: the output register holds, the back pipeline fills, then
//   the queue (QueueDepth entries) fills and in_stall_o rises.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 prop, 1 integ, 2 deriv gain, 3 upper, 4 lower clamp); write only when
//   idle. Other indexes are ignored.
//   Reset: gains 256/0/0, clamps 32767/-32768, direction forward, integral and
//   last speed zero, queue and pipeline empty.
`default_nettype none

module motor_speed_pid_with_reversal_guard #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  mspid_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output mspid_pkg::out_item_t               out_data_o,
  input  wire                                cfg_we_i,
  input  wire [mspid_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [mspid_pkg::CfgW-1:0]          cfg_wdata_i
);
  import mspid_pkg::*;

  cfg_t  cfg_q;
  logic  q_full, q_valid, push, pop;
  tick_t push_tick, pop_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= 16'sd256;
      cfg_q.integ_gain  <= 16'sd0;
      cfg_q.deriv_gain  <= 16'sd0;
      cfg_q.integ_upper <= 16'sh7fff;
      cfg_q.integ_lower <= 16'sh8000;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPropGain:  cfg_q.prop_gain   <= cfg_wdata_i;
        CfgIntegGain: cfg_q.integ_gain  <= cfg_wdata_i;
        CfgDerivGain: cfg_q.deriv_gain  <= cfg_wdata_i;
        CfgIntegUp:   cfg_q.integ_upper <= cfg_wdata_i;
        CfgIntegLow:  cfg_q.integ_lower <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mspid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .tick_o     (push_tick)
  );

  mspid_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tick),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (pop_tick)
  );

  mspid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_tick),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
